### hw/rtl/swb_pkg.sv
package swb_pkg;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_PRESENT  = 2'd1,
      ST_BELOW    = 2'd2,
      ST_ABSENT   = 2'd3
   } status_type;

   typedef struct packed {
      op_type      req_type;
      logic [31:0] seq;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] earliest;
      logic [31:0] latest;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL,
      S_SLOT,
      S_READ,
      S_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_step;
      logic load;
      logic eval;
      logic slot_near;
      logic rd;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic needs_slot;
   } sts_type;

endpackage

### hw/rtl/swb_ram.sv
module swb_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [WIDTH-1:0] rd_data_in;

   always_comb begin
      rd_data_in = rd_en ? mem[rd_addr] : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= rd_data_in;
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/swb_dp.sv
module swb_dp
   import swb_pkg::*;
#(
   parameter int WINDOW    = 64,
   parameter int SEQ_WIDTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output sts_type         sts,
   input  req_payload_type req_payload,
   output rsp_payload_type rsp_payload
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CMP_W = ((SEQ_WIDTH > IDX_W) ? SEQ_WIDTH : IDX_W) + 1;
   localparam int TAG_W = SEQ_WIDTH + 1;
   localparam logic [CMP_W-1:0] WIN_C     = CMP_W'(WINDOW);
   localparam logic [CMP_W-1:0] WIN_M1_C  = CMP_W'(WINDOW - 1);
   localparam logic [IDX_W:0]   WIN_R     = (IDX_W + 1)'(WINDOW);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW - 1);

   // Item registers
   op_type               op_ff, op_in;
   logic [SEQ_WIDTH-1:0] s_ff, s_in;
   logic                 below_ff, below_in;
   logic                 above_ff, above_in;
   logic                 far_ff, far_in;
   logic                 adv_ff, adv_in;
   logic [IDX_W-1:0]     dist_ff, dist_in;
   logic [SEQ_WIDTH-1:0] cand_ff, cand_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;

   // Window state
   logic [SEQ_WIDTH-1:0] ws_ff, ws_in;
   logic [SEQ_WIDTH-1:0] hs_ff, hs_in;
   logic [IDX_W-1:0]     hslot_ff, hslot_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;

   rsp_payload_type      rsp_ff, rsp_in;

   logic [SEQ_WIDTH+31:0] seq_wide;
   logic [SEQ_WIDTH+31:0] ws_wide;
   logic [SEQ_WIDTH+31:0] hs_wide;
   logic [CMP_W-1:0]      s_c, ws_c, hs_c, up_c, dn_c, cand_c;
   logic [IDX_W:0]        up_sum, up_wrap, dn_diff, dn_wrap;
   logic [IDX_W-1:0]      slot_near;
   logic                  in_win, hit, do_write;
   status_type            status_c;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [TAG_W-1:0]      wr_data;
   logic [TAG_W-1:0]      rd_data;

   // The tag store keeps the number that last marked each slot. A slot
   // counts as marked for a number only when the tag matches it, so slots
   // of numbers that left the window never need an explicit clear.
   swb_ram #(
      .WIDTH (TAG_W),
      .DEPTH (WINDOW)
   ) u_tags (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   assign seq_wide = {{SEQ_WIDTH{1'b0}}, req_payload.seq};

   always_comb begin
      s_c    = CMP_W'(s_ff);
      ws_c   = CMP_W'(ws_ff);
      hs_c   = CMP_W'(hs_ff);
      up_c   = s_c - hs_c;
      dn_c   = hs_c - s_c;
      cand_c = s_c - WIN_M1_C;
   end

   // Slot of a number within WINDOW of the highest one, from the slot of
   // the highest number. After a jump of WINDOW or more the window holds
   // only the new number, so it simply takes over the slot of the old
   // highest number; every other tag then belongs to a number below the
   // window and can never match.
   always_comb begin
      up_sum  = {1'b0, hslot_ff} + {1'b0, dist_ff};
      up_wrap = (up_sum >= WIN_R) ? (up_sum - WIN_R) : up_sum;
      dn_diff = {1'b0, hslot_ff} - {1'b0, dist_ff};
      dn_wrap = {1'b0, hslot_ff} + WIN_R - {1'b0, dist_ff};
      if (far_ff) begin
         slot_near = hslot_ff;
      end else if (above_ff) begin
         slot_near = up_wrap[IDX_W-1:0];
      end else if (hslot_ff >= dist_ff) begin
         slot_near = dn_diff[IDX_W-1:0];
      end else begin
         slot_near = dn_wrap[IDX_W-1:0];
      end
   end

   always_comb begin
      in_win   = !below_ff && !above_ff;
      hit      = rd_data[SEQ_WIDTH] && (rd_data[SEQ_WIDTH-1:0] == s_ff);
      do_write = cmd.commit && (op_ff == OP_INSERT) && !below_ff && !(in_win && hit);
      if (op_ff == OP_QUERY) begin
         status_c = (in_win && hit) ? ST_PRESENT : ST_ABSENT;
      end else if (below_ff) begin
         status_c = ST_BELOW;
      end else if (in_win && hit) begin
         status_c = ST_PRESENT;
      end else begin
         status_c = ST_INSERTED;
      end
   end

   always_comb begin
      op_in    = op_ff;
      s_in     = s_ff;
      below_in = below_ff;
      above_in = above_ff;
      far_in   = far_ff;
      adv_in   = adv_ff;
      dist_in  = dist_ff;
      cand_in  = cand_ff;
      slot_in  = slot_ff;
      ws_in    = ws_ff;
      hs_in    = hs_ff;
      hslot_in = hslot_ff;
      clr_in   = clr_ff;
      rsp_in   = rsp_ff;

      if (cmd.clr_step) begin
         clr_in = clr_ff + IDX_W'(1);
      end
      if (cmd.load) begin
         op_in = req_payload.req_type;
         s_in  = seq_wide[SEQ_WIDTH-1:0];
      end
      if (cmd.eval) begin
         below_in = s_c < ws_c;
         above_in = s_c > hs_c;
         far_in   = (s_c > hs_c) && (up_c >= WIN_C);
         dist_in  = (s_c > hs_c) ? up_c[IDX_W-1:0] : dn_c[IDX_W-1:0];
         adv_in   = (s_c >= WIN_M1_C) && (cand_c > ws_c);
         cand_in  = cand_c[SEQ_WIDTH-1:0];
      end
      if (cmd.slot_near) begin
         slot_in = slot_near;
      end
      if (do_write && above_ff) begin
         hs_in    = s_ff;
         hslot_in = slot_ff;
         if (adv_ff) begin
            ws_in = cand_ff;
         end
      end
      ws_wide = {32'd0, ws_in};
      hs_wide = {32'd0, hs_in};
      if (cmd.commit) begin
         rsp_in.status   = status_c;
         rsp_in.earliest = ws_wide[31:0];
         rsp_in.latest   = hs_wide[31:0];
      end
   end

   always_comb begin
      wr_en = cmd.clr_step || do_write;
      if (cmd.clr_step) begin
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_addr = slot_ff;
         wr_data = {1'b1, s_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff    <= '0;
         hs_ff    <= '0;
         hslot_ff <= '0;
         clr_ff   <= '0;
      end else begin
         ws_ff    <= ws_in;
         hs_ff    <= hs_in;
         hslot_ff <= hslot_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      s_ff     <= s_in;
      below_ff <= below_in;
      above_ff <= above_in;
      far_ff   <= far_in;
      adv_ff   <= adv_in;
      dist_ff  <= dist_in;
      cand_ff  <= cand_in;
      slot_ff  <= slot_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      sts.clr_last   = clr_ff == LAST_SLOT;
      sts.needs_slot = !below_ff && (!above_ff || (op_ff == OP_INSERT));
   end

   assign rsp_payload = rsp_ff;

   a_window_order: assert property (@(posedge clock) disable iff (reset)
      ws_ff <= hs_ff)
      else $error("window start is above the highest number");

   a_window_span: assert property (@(posedge clock) disable iff (reset)
      (hs_c - ws_c) < WIN_C)
      else $error("window span reached WINDOW");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |-> ({1'b0, slot_ff} < WIN_R))
      else $error("tag store read beyond the last slot");

endmodule

### hw/rtl/swb_ctrl.sv
module swb_ctrl
   import swb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_SLOT;
         end
         S_SLOT: begin
            if (!sts.needs_slot) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
         end
         S_SLOT: begin
            cmd.slot_near = sts.needs_slot;
         end
         S_READ: begin
            cmd.rd = 1'b1;
         end
         S_FINISH: begin
            cmd.commit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_EVAL))
      else $error("accepted item did not move on to evaluation");

   a_ready_in_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == S_IDLE))
      else $error("input ready outside the idle state");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("result dropped before it was taken");

endmodule

### hw/rtl/sequence_window_bitmap.sv
// Sequence: an accepted item passes the evaluate, slot, tag store read
// and finish states before its result is valid; an insert below the
// window or a query outside it skips the read state. The finish state
// waits while an earlier result is held by the result side. A new item
// is accepted only in the idle state, once the last one is finished.
// Reset: synchronous; a clearing pass over each slot empties the tag store.
module sequence_window_bitmap
   import swb_pkg::*;
#(
   parameter int WINDOW    = 64,
   parameter int SEQ_WIDTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   cmd_type cmd;
   sts_type sts;

   swb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   swb_dp #(
      .WINDOW    (WINDOW),
      .SEQ_WIDTH (SEQ_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule
